FILE: sv/bfr_pkg.sv
// Shared types and constants for the bilinear feature resampler.
// No dependencies.
package bfr_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int QUEUE_DEPTH    = 4;
    localparam int ACC_W          = 50;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [1:0] REG_PLANE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PLANE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INV_FACTOR   = 2'd2;
    localparam logic [1:0] REG_PASSTHROUGH  = 2'd3;

    localparam logic [6:0]  RST_PLANE_WIDTH  = 7'd64;
    localparam logic [6:0]  RST_PLANE_HEIGHT = 7'd64;
    localparam logic [17:0] RST_INV_FACTOR   = 18'd65536;
    localparam logic        RST_PASSTHROUGH  = 1'b1;

    // plane size after clamping to the store limits
    typedef struct packed {
        logic [6:0] w;
        logic [6:0] h;
    } t_geom;

    // classified request, as held in the queue
    typedef struct packed {
        logic        cmd;
        logic        oor;
        logic [6:0]  xi;
        logic [6:0]  yi;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [11:0] addr;
        logic [15:0] sample;
    } t_item;

endpackage

FILE: sv/bfr_front.sv
// Front end: maps a request to source coordinates and flags points outside the plane.
// Depends on bfr_pkg.
module bfr_front
    import bfr_pkg::*;
(
    input  logic        i_command,
    input  logic [11:0] i_address,
    input  logic [15:0] i_sample,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  t_geom       i_geom,
    input  logic [17:0] i_inv_factor,
    input  logic        i_passthrough,
    output t_item       o_item
);

    logic [23:0] xp;
    logic [23:0] yp;
    logic [7:0]  xi;
    logic [7:0]  yi;
    logic [15:0] fx;
    logic [15:0] fy;

    always_comb begin
        xp = 24'(i_col) * 24'(i_inv_factor);
        yp = 24'(i_row) * 24'(i_inv_factor);
        if (i_passthrough) begin
            // copy mode is the blend with zero fractions
            xi = 8'(i_col);
            yi = 8'(i_row);
            fx = '0;
            fy = '0;
        end else begin
            xi = xp[23:16];
            yi = yp[23:16];
            fx = xp[15:0];
            fy = yp[15:0];
        end
        o_item.cmd    = i_command;
        o_item.oor    = !((xi < 8'(i_geom.w)) && (yi < 8'(i_geom.h)));
        o_item.xi     = xi[6:0];
        o_item.yi     = yi[6:0];
        o_item.fx     = fx;
        o_item.fy     = fy;
        o_item.addr   = i_address;
        o_item.sample = i_sample;
    end

endmodule

FILE: sv/bfr_queue.sv
// Short request queue between front and back end.
// Depends on bfr_pkg.
module bfr_queue
    import bfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item         r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: sv/bfr_back.sv
// Back end: plane memory, four-neighbour read sequence, weight multiply and accumulate,
// output register. Depends on bfr_pkg.
module bfr_back
    import bfr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    input  t_geom       i_geom,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_value,
    output logic        o_out_of_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0] r_mem [DEPTH];

    logic        r_busy;
    logic        r_issue;
    logic [1:0]  r_k;
    logic [6:0]  r_xi;
    logic [6:0]  r_yi;
    logic [15:0] r_fx;
    logic [15:0] r_fy;

    logic        r_s1_v, r_s1_en, r_s1_last;
    logic [16:0] r_s1_wx, r_s1_wy;
    logic [15:0] r_rdata;
    logic        r_s2_v, r_s2_last;
    logic [16:0] r_s2_wy;
    logic signed [33:0] r_p1;
    logic        r_s3_v, r_s3_last;
    logic signed [ACC_W-1:0] r_p2;
    logic signed [ACC_W-1:0] r_acc;

    logic        r_out_v;
    logic [15:0] r_out_value;
    logic        r_out_oor;

    logic        pop;
    logic        pop_wr;
    logic        pop_oor;
    logic        pop_run;
    logic [7:0]  nx, ny;
    logic        n_en;
    logic [31:0] idx32;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;
    logic        wr_ok;
    logic [16:0] wx, wy;
    logic signed [ACC_W-1:0] sum;
    logic signed [16:0] q;
    logic [15:0] sat;

    always_comb begin
        pop     = i_q_valid && !r_busy && ((i_q_item.cmd == CMD_WRITE) || !r_out_v);
        pop_wr  = pop && (i_q_item.cmd == CMD_WRITE);
        pop_oor = pop && (i_q_item.cmd == CMD_REQUEST) && i_q_item.oor;
        pop_run = pop && (i_q_item.cmd == CMD_REQUEST) && !i_q_item.oor;

        wr_ok  = (32'(i_q_item.addr) < 32'(DEPTH));
        wr_idx = AW'(32'(i_q_item.addr));

        nx    = 8'(r_xi) + 8'(r_k[0]);
        ny    = 8'(r_yi) + 8'(r_k[1]);
        // zero-weight neighbours are skipped, so copy mode uses only its own sample
        n_en  = (nx < 8'(i_geom.w)) && (ny < 8'(i_geom.h)) &&
                (!r_k[0] || (r_fx != '0)) && (!r_k[1] || (r_fy != '0));
        idx32 = 32'(ny) * 32'(i_geom.w) + 32'(nx);
        rd_idx = n_en ? AW'(idx32) : '0;
        wx    = r_k[0] ? 17'(r_fx) : (17'h10000 - 17'(r_fx));
        wy    = r_k[1] ? 17'(r_fy) : (17'h10000 - 17'(r_fy));

        // floor to Q8.8 is the top bits of the exact sum
        sum = r_acc + r_p2;
        q   = sum[48:32];
        if (q > 17'sd32767) begin
            sat = 16'h7FFF;
        end else if (q < -17'sd32768) begin
            sat = 16'h8000;
        end else begin
            sat = q[15:0];
        end
    end

    assign o_q_pop        = pop;
    assign o_valid        = r_out_v;
    assign o_value        = r_out_value;
    assign o_out_of_range = r_out_oor;

    always_ff @(posedge i_clk) begin
        if (pop_wr && wr_ok) begin
            r_mem[wr_idx] <= i_q_item.sample;
        end
        r_rdata <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issue   <= 1'b0;
            r_k       <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (pop_run) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
                r_k     <= '0;
            end else if (r_issue) begin
                r_k <= r_k + 1'b1;
                if (r_k == 2'd3) begin
                    r_issue <= 1'b0;
                end
            end
            r_s1_v <= r_issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;

            if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end
            if (pop_oor) begin
                r_out_v <= 1'b1;
            end
            if (r_s3_v && r_s3_last) begin
                r_out_v <= 1'b1;
                r_busy  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_run) begin
            r_xi  <= i_q_item.xi;
            r_yi  <= i_q_item.yi;
            r_fx  <= i_q_item.fx;
            r_fy  <= i_q_item.fy;
            r_acc <= '0;
        end else if (r_s3_v) begin
            r_acc <= sum;
        end
        r_s1_en   <= n_en;
        r_s1_last <= (r_k == 2'd3);
        r_s1_wx   <= wx;
        r_s1_wy   <= wy;
        r_s2_last <= r_s1_last;
        r_s2_wy   <= r_s1_wy;
        r_p1      <= r_s1_en ? ($signed({1'b0, r_s1_wx}) * $signed(r_rdata)) : 34'sd0;
        r_s3_last <= r_s2_last;
        r_p2      <= ACC_W'(r_p1) * ACC_W'($signed({1'b0, r_s2_wy}));
        if (pop_oor) begin
            r_out_value <= '0;
            r_out_oor   <= 1'b1;
        end else if (r_s3_v && r_s3_last) begin
            r_out_value <= sat;
            r_out_oor   <= 1'b0;
        end
    end

endmodule

FILE: sv/bilinear_feature_resampler_unit.sv
// Top level of the bilinear feature resampler: register port, front end, queue, back end.
// Depends on bfr_pkg, bfr_front, bfr_queue, bfr_back.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_command i_address i_sample i_row i_col
//   output    out        o_out_valid / i_out_stall o_value o_out_of_range
//   config    in         psel penable pwrite pready paddr pwdata prdata
//
// A write or a request outside the plane is handled as the back end pops it; an
// interpolated or copied request issues four neighbour reads through the single
// memory read port, then the multiply and accumulate pipeline drains.
// Reset is synchronous; the plane memory is not cleared.
// Requests queue up (4 deep) while a result waits under stall.
module bilinear_feature_resampler_unit
    import bfr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [11:0] i_address,
    input  logic [15:0] i_sample,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_value,
    output logic        o_out_of_range,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]  r_plane_width;
    logic [6:0]  r_plane_height;
    logic [17:0] r_inv_factor;
    logic        r_passthrough;

    t_geom geom;
    t_item f_item;
    t_item q_item;
    logic  q_full, q_valid, q_pop, push;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_width  <= RST_PLANE_WIDTH;
            r_plane_height <= RST_PLANE_HEIGHT;
            r_inv_factor   <= RST_INV_FACTOR;
            r_passthrough  <= RST_PASSTHROUGH;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_PLANE_WIDTH:  r_plane_width  <= pwdata[6:0];
                REG_PLANE_HEIGHT: r_plane_height <= pwdata[6:0];
                REG_INV_FACTOR:   r_inv_factor   <= pwdata[17:0];
                REG_PASSTHROUGH:  r_passthrough  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PLANE_WIDTH:  prdata = 32'(r_plane_width);
            REG_PLANE_HEIGHT: prdata = 32'(r_plane_height);
            REG_INV_FACTOR:   prdata = 32'(r_inv_factor);
            REG_PASSTHROUGH:  prdata = 32'(r_passthrough);
            default:          prdata = '0;
        endcase
        geom.w = (32'(r_plane_width) > 32'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : r_plane_width;
        geom.h = (32'(r_plane_height) > 32'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : r_plane_height;
    end

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    bfr_front u_front (
        .i_command     (i_command),
        .i_address     (i_address),
        .i_sample      (i_sample),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_geom        (geom),
        .i_inv_factor  (r_inv_factor),
        .i_passthrough (r_passthrough),
        .o_item        (f_item)
    );

    bfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bfr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .i_geom         (geom),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_value        (o_value),
        .o_out_of_range (o_out_of_range)
    );

endmodule

FILE: sv/bfr_checker.sv
// Port-level checks for the bilinear feature resampler, bound to the top level.
// Depends on bilinear_feature_resampler_unit.
module bfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_value,
    input logic        o_out_of_range,
    input logic        pready
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    a_hold_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_value) && $stable(o_out_of_range))
        else $error("result changed under stall");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_value == 16'h0000)
        else $error("out-of-range result not zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> pready)
        else $error("register port not ready");

endmodule

bind bilinear_feature_resampler_unit bfr_checker u_bfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_value        (o_value),
    .o_out_of_range (o_out_of_range),
    .pready         (pready)
);

FILE: test/bilinear_feature_resampler_unit_tb.sv
// Self-checking testbench for bilinear_feature_resampler_unit: directed table, then random
// plane writes and pixel requests checked against an in-bench predictor of the resampler.
// Depends on bfr_pkg and the RTL of the block.
module bilinear_feature_resampler_unit_tb;
    import bfr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 40;
    localparam int STORE_SIZE  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    typedef struct {
        logic [15:0] value;
        logic        oor;
    } t_pixel;

    typedef enum int {ROW_CFG, ROW_WR, ROW_RD} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        int unsigned arg;     // register index or store address
        int unsigned data;    // register value or sample
        int unsigned row;
        int unsigned col;
        bit          typed;
        logic [15:0] exp_value;
        logic        exp_oor;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = CMD_WRITE;
    logic [11:0] i_address = '0;
    logic [15:0] i_sample = '0;
    logic [5:0]  i_row = '0;
    logic [5:0]  i_col = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_value;
    logic        o_out_of_range;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bilinear_feature_resampler_unit DUT (.*);

    always #6 i_clk = ~i_clk;

    // mirror of the block state
    logic [15:0] plane_mem [STORE_SIZE];
    bit          plane_written [STORE_SIZE];
    int unsigned cfg_w = 64, cfg_h = 64, cfg_f = 65536;
    bit          cfg_pass = 1'b1;

    t_pixel pending_pixels[$];
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     cycles = 0;
    int     errors = 0;
    int     sent = 0;
    bit     use_typed = 1'b0;
    t_pixel typed_pixel;
    t_dir_row dir_tab[$];

    function automatic int unsigned clamp64(input int unsigned v);
        return (v > 64) ? 64 : v;
    endfunction

    function automatic t_pixel predict_pixel(input int unsigned row, input int unsigned col);
        t_pixel res;
        int unsigned w, h, xp, yp, xi, yi, x, y;
        longint unsigned wx[2], wy[2];
        longint acc, q;
        w = clamp64(cfg_w);
        h = clamp64(cfg_h);
        res.value = '0;
        res.oor = 1'b0;
        if (cfg_pass) begin
            if (row < h && col < w) res.value = plane_mem[row * w + col];
            else res.oor = 1'b1;
            return res;
        end
        xp = col * cfg_f;
        yp = row * cfg_f;
        xi = xp >> 16;
        yi = yp >> 16;
        if (!(xi < w && yi < h)) begin
            res.oor = 1'b1;
            return res;
        end
        wx[1] = xp & 32'hFFFF;
        wx[0] = 65536 - wx[1];
        wy[1] = yp & 32'hFFFF;
        wy[0] = 65536 - wy[1];
        acc = 0;
        for (int dx = 0; dx < 2; dx++) begin
            for (int dy = 0; dy < 2; dy++) begin
                x = xi + dx;
                y = yi + dy;
                if (x < w && y < h)
                    acc += longint'(wx[dx] * wy[dy]) * longint'($signed(plane_mem[y * w + x]));
            end
        end
        q = acc >>> 32;   // floor to Q8.8
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        res.value = q[15:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result value=%h oor=%b", o_value,
                                           o_out_of_range);
            end else begin
                want = pending_pixels.pop_front();
                if (o_value !== want.value || o_out_of_range !== want.oor) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected value=%h oor=%b, got value=%h oor=%b",
                                 want.value, want.oor, o_value, o_out_of_range);
                end
            end
        end
    end

    task automatic send_raw(input logic cmd, input int unsigned addr, input int unsigned samp,
                            input int unsigned row, input int unsigned col);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_address  <= addr[11:0];
        i_sample   <= samp[15:0];
        i_row      <= row[5:0];
        i_col      <= col[5:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        if (cmd == CMD_WRITE) begin
            plane_mem[addr[11:0]] = samp[15:0];
            plane_written[addr[11:0]] = 1'b1;
        end else if (use_typed) begin
            pending_pixels.push_back(typed_pixel);
            use_typed = 1'b0;
        end else begin
            pending_pixels.push_back(predict_pixel(row, col));
        end
    endtask

    // a request first gets every plane entry it will read written
    task automatic send_request(input int unsigned row, input int unsigned col);
        int unsigned w, h, xi, yi, a;
        w = clamp64(cfg_w);
        h = clamp64(cfg_h);
        if (cfg_pass) begin
            if (row < h && col < w) begin
                a = row * w + col;
                if (!plane_written[a]) send_raw(CMD_WRITE, a, $urandom, $urandom, $urandom);
            end
        end else begin
            xi = (col * cfg_f) >> 16;
            yi = (row * cfg_f) >> 16;
            if (xi < w && yi < h) begin
                for (int dx = 0; dx < 2; dx++) begin
                    for (int dy = 0; dy < 2; dy++) begin
                        if (xi + dx < w && yi + dy < h) begin
                            a = (yi + dy) * w + xi + dx;
                            if (!plane_written[a])
                                send_raw(CMD_WRITE, a, $urandom, $urandom, $urandom);
                        end
                    end
                end
            end
        end
        send_raw(CMD_REQUEST, $urandom, $urandom, row, col);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PLANE_WIDTH:  cfg_w = val & 32'h7F;
            REG_PLANE_HEIGHT: cfg_h = val & 32'h7F;
            REG_INV_FACTOR:   cfg_f = val & 32'h3FFFF;
            REG_PASSTHROUGH:  cfg_pass = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_extent();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return 0;
        if (r < 16) return 127;
        if (r < 30) return 64;
        if (r < 40) return 1;
        return $urandom_range(1, 64);
    endfunction

    function automatic int unsigned pick_coord(input int unsigned ext);
        int unsigned lim;
        ext = clamp64(ext);
        if (ext == 0 || $urandom_range(99) < 15) return $urandom_range(0, 63);
        if (cfg_pass || cfg_f == 0) lim = ext - 1;
        else lim = (ext * 65536 - 1) / cfg_f;
        if (lim > 63) lim = 63;
        return $urandom_range(0, lim);
    endfunction

    initial begin
        t_dir_row d;
        int unsigned f, r;

        // reset state: 64x64 plane, passthrough
        dir_tab.push_back('{ROW_WR, 0, 16'h7FFF, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 0, 0, 1, 16'h7FFF, 0});
        dir_tab.push_back('{ROW_WR, 4095, 16'h8000, 63, 63, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 63, 63, 1, 16'h8000, 0});
        dir_tab.push_back('{ROW_WR, 12'hAB5, 16'h5A5A, 42, 21, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 42, 53, 0, 0, 0});
        // empty plane
        dir_tab.push_back('{ROW_CFG, REG_PLANE_WIDTH, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 5, 5, 1, 16'h0000, 1});
        dir_tab.push_back('{ROW_RD, 0, 0, 0, 0, 1, 16'h0000, 1});
        // oversized width saturates, single row
        dir_tab.push_back('{ROW_CFG, REG_PLANE_WIDTH, 127, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, REG_PLANE_HEIGHT, 1, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 0, 63, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 1, 0, 1, 16'h0000, 1});
        // zero factor maps everything to the origin
        dir_tab.push_back('{ROW_CFG, REG_PLANE_HEIGHT, 64, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, REG_PASSTHROUGH, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_CFG, REG_INV_FACTOR, 0, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 63, 63, 1, 16'h7FFF, 0});
        // largest factor
        dir_tab.push_back('{ROW_CFG, REG_INV_FACTOR, 262143, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 0, 0, 1, 16'h7FFF, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 0, 1, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 15, 15, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 63, 63, 1, 16'h0000, 1});
        // half-step upsampling, negative samples blended and floored
        dir_tab.push_back('{ROW_CFG, REG_INV_FACTOR, 32768, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_WR, 64 * 1 + 2, 16'hFF01, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_WR, 64 * 1 + 3, 16'h8000, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 3, 5, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 63, 63, 0, 0, 0});
        // right edge: last two columns and rows blended, no neighbour beyond the plane
        dir_tab.push_back('{ROW_CFG, REG_INV_FACTOR, 65535, 0, 0, 0, 0, 0});
        dir_tab.push_back('{ROW_RD, 0, 0, 63, 63, 0, 0, 0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            d = dir_tab[k];
            case (d.kind)
                ROW_CFG: begin
                    drain();
                    cfg_write(d.arg[1:0], d.data);
                end
                ROW_WR: send_raw(CMD_WRITE, d.arg, d.data, d.row, d.col);
                default: begin
                    use_typed = d.typed;
                    typed_pixel.value = d.exp_value;
                    typed_pixel.oor = d.exp_oor;
                    send_request(d.row, d.col);
                end
            endcase
        end

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct  = (ph == 0) ? 21 : (ph == 1) ? 62 : 0;
            stall_pct = (ph == 0) ? 62 : (ph == 1) ? 21 : 0;
            for (int seg = 0; seg < 5; seg++) begin
                drain();
                cfg_write(REG_PLANE_WIDTH, pick_extent());
                cfg_write(REG_PLANE_HEIGHT, pick_extent());
                r = $urandom_range(99);
                if (r < 8) f = 0;
                else if (r < 16) f = 262143;
                else if (r < 50) f = $urandom_range(1, 262143);
                else f = $urandom_range(16384, 98304);
                cfg_write(REG_INV_FACTOR, f);
                cfg_write(REG_PASSTHROUGH, $urandom_range(0, 1));
                // every segment tops the item count up to its share of the total
                while (sent < 70 * (ph * 5 + seg + 1)) begin
                    if ($urandom_range(99) < 35)
                        send_raw(CMD_WRITE, $urandom, $urandom, $urandom, $urandom);
                    else
                        send_request(pick_coord(cfg_h), pick_coord(cfg_w));
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
